// ===== hw/rtl/ebnf_pkg.sv =====
// ----------------------------------------------------------------------------
// ebnf_pkg
// Shared types, codes and byte classification for the EBNF tokenizer.
// ----------------------------------------------------------------------------
package ebnf_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned RBUF_DEPTH        = 4;

  typedef enum logic [2:0] {
    M_IDLE,
    M_IDENT,
    M_PAREN,
    M_COMMENT,
    M_COMMENT_STAR,
    M_DQ,
    M_SQ,
    M_ANGLE
  } mode_t;

  localparam logic [4:0] K_IDENT      = 5'd0;
  localparam logic [4:0] K_EQUALS     = 5'd1;
  localparam logic [4:0] K_COMMA      = 5'd2;
  localparam logic [4:0] K_SEMI       = 5'd3;
  localparam logic [4:0] K_BAR        = 5'd4;
  localparam logic [4:0] K_LBRACKET   = 5'd5;
  localparam logic [4:0] K_RBRACKET   = 5'd6;
  localparam logic [4:0] K_LBRACE     = 5'd7;
  localparam logic [4:0] K_RBRACE     = 5'd8;
  localparam logic [4:0] K_OPEN_GROUP = 5'd9;
  localparam logic [4:0] K_CLOSE_GRP  = 5'd10;
  localparam logic [4:0] K_DQ         = 5'd11;
  localparam logic [4:0] K_SQ         = 5'd12;
  localparam logic [4:0] K_MINUS      = 5'd13;
  localparam logic [4:0] K_PERIOD     = 5'd14;
  localparam logic [4:0] K_UNKNOWN    = 5'd15;
  localparam logic [4:0] K_END        = 5'd16;
  localparam logic [4:0] K_ERROR      = 5'd17;

  localparam logic [2:0] E_NONE         = 3'd0;
  localparam logic [2:0] E_OPEN_COMMENT = 3'd1;
  localparam logic [2:0] E_OPEN_LITERAL = 3'd2;
  localparam logic [2:0] E_EOF_PAREN    = 3'd3;
  localparam logic [2:0] E_NO_RANGLE    = 3'd4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    mode_t      mode;
    logic       emit;
    logic [4:0] kind;
  } byte_cls_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } res_ctl_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_ident_char(input logic [7:0] b);
    return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDER);
  endfunction

  // Classification of a byte seen between tokens.
  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    c.mode = M_IDLE;
    c.emit = 1'b1;
    c.kind = K_UNKNOWN;
    if (is_letter(b)) begin
      c.mode = M_IDENT;
      c.emit = 1'b0;
    end else begin
      unique case (b) inside
        CH_SPACE, CH_TAB, CH_CR, CH_LF: c.emit = 1'b0;
        CH_LPAREN: begin c.mode = M_PAREN; c.emit = 1'b0; end
        CH_DQUOTE: begin c.mode = M_DQ;    c.emit = 1'b0; end
        CH_SQUOTE: begin c.mode = M_SQ;    c.emit = 1'b0; end
        CH_LT:     begin c.mode = M_ANGLE; c.emit = 1'b0; end
        CH_EQUALS: c.kind = K_EQUALS;
        CH_COMMA:  c.kind = K_COMMA;
        CH_SEMI:   c.kind = K_SEMI;
        CH_BAR:    c.kind = K_BAR;
        CH_LBRACK: c.kind = K_LBRACKET;
        CH_RBRACK: c.kind = K_RBRACKET;
        CH_LBRACE: c.kind = K_LBRACE;
        CH_RBRACE: c.kind = K_RBRACE;
        CH_RPAREN: c.kind = K_CLOSE_GRP;
        CH_MINUS:  c.kind = K_MINUS;
        CH_PERIOD: c.kind = K_PERIOD;
        default:   c.kind = K_UNKNOWN;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ebnf_grammar_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ebnf_grammar_tokenizer
// EBNF grammar lexer: one text byte per item in, zero, one or two tokens per item out.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  text      text_valid/text_stall   text_byte, end_of_text
//  token     token_valid/token_stall token_kind, start_line, start_column,
//                                    start_offset, token_length, error_code,
//                                    last_of_run
//
//  One text item per cycle while text_stall is low; scan state updates in the accepting cycle.
//  An item gives zero, one or two tokens; tokens leave one per cycle from a
//  four-entry queue while token_stall is low, so text_stall rises when fewer
//  than two slots are free. Tokens from an accepted item are registered into the queue.
//  Synchronous reset clears scan state, counters and the queue; text_stall
//  is held high while rst is high.
//  After an error token the block takes items and yields nothing until reset.
// ----------------------------------------------------------------------------
module ebnf_grammar_tokenizer #(
  parameter int unsigned POSITION_BITS = ebnf_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     text_valid,
  output logic                     text_stall,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_text,
  output logic                     token_valid,
  input  logic                     token_stall,
  output logic [4:0]               token_kind,
  output logic [POSITION_BITS-1:0] start_line,
  output logic [POSITION_BITS-1:0] start_column,
  output logic [POSITION_BITS-1:0] start_offset,
  output logic [POSITION_BITS-1:0] token_length,
  output logic [2:0]               error_code,
  output logic                     last_of_run
);
  import ebnf_pkg::*;

  localparam int unsigned P        = POSITION_BITS;
  localparam int unsigned REC_BITS = 4 * P + 9;

  res_ctl_t            ctl;
  logic [REC_BITS-1:0] res0, res1, out_rec;
  logic                room, step;

  assign text_stall = rst || !room;
  assign step       = text_valid && !text_stall;

  ebnf_tok_core #(
    .POSITION_BITS (P),
    .REC_BITS      (REC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .ctl         (ctl),
    .res0        (res0),
    .res1        (res1)
  );

  ebnf_tok_rbuf #(
    .REC_BITS (REC_BITS)
  ) u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (token_valid),
    .out_stall (token_stall),
    .out_rec   (out_rec)
  );

  assign last_of_run  = out_rec[REC_BITS-1];
  assign error_code   = out_rec[REC_BITS-2 -: 3];
  assign token_kind   = out_rec[REC_BITS-5 -: 5];
  assign start_line   = out_rec[4*P-1 -: P];
  assign start_column = out_rec[3*P-1 -: P];
  assign start_offset = out_rec[2*P-1 -: P];
  assign token_length = out_rec[P-1:0];

endmodule

// ===== hw/rtl/ebnf_tok_core.sv =====
// ----------------------------------------------------------------------------
// ebnf_tok_core
// Scan state, position counters and per-byte token decisions. Produces up to
// two result records per item.
// ----------------------------------------------------------------------------
module ebnf_tok_core #(
  parameter int unsigned POSITION_BITS = ebnf_pkg::POSITION_BITS_DEF,
  parameter int unsigned REC_BITS      = 4 * POSITION_BITS + 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  output ebnf_pkg::res_ctl_t    ctl,
  output logic [REC_BITS-1:0]   res0,
  output logic [REC_BITS-1:0]   res1
);
  import ebnf_pkg::*;

  localparam int unsigned P = POSITION_BITS;

  mode_t        mode, mode_next;
  logic [P-1:0] cur_line, cur_line_next;
  logic [P-1:0] cur_col, cur_col_next;
  logic [P-1:0] byte_off, byte_off_next;
  logic [P-1:0] tok_line, tok_line_next;
  logic [P-1:0] tok_col, tok_col_next;
  logic [P-1:0] tok_off, tok_off_next;
  logic [P-1:0] tok_len, tok_len_next;
  logic         halted, halted_next;

  logic         pf_v, id_v, end_v, adv, take_idle, second_v;
  logic [4:0]   pf_kind, id_kind;
  logic [2:0]   pf_err;
  logic [P-1:0] pf_len, len_inc;
  byte_cls_t    cls;
  logic         ident_ch;
  logic [REC_BITS-2:0] rec_pf, rec_second;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == {P{1'b1}}) ? v : P'(v + 1'b1);
  endfunction

  always_comb begin
    mode_next     = mode;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    byte_off_next = byte_off;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    tok_len_next  = tok_len;
    halted_next   = halted;
    pf_v      = 1'b0;
    pf_kind   = K_IDENT;
    pf_err    = E_NONE;
    pf_len    = tok_len;
    id_v      = 1'b0;
    id_kind   = K_UNKNOWN;
    end_v     = 1'b0;
    adv       = 1'b0;
    take_idle = 1'b0;
    cls       = classify(text_byte);
    ident_ch  = is_ident_char(text_byte);
    len_inc   = sat_inc(tok_len);

    if (step && !halted) begin
      if (end_of_text) begin
        unique case (mode)
          M_IDENT: begin
            pf_v      = 1'b1;
            end_v     = 1'b1;
            mode_next = M_IDLE;
          end
          M_PAREN: begin
            pf_v = 1'b1; pf_kind = K_ERROR; pf_err = E_EOF_PAREN; halted_next = 1'b1;
          end
          M_COMMENT, M_COMMENT_STAR: begin
            pf_v = 1'b1; pf_kind = K_ERROR; pf_err = E_OPEN_COMMENT; halted_next = 1'b1;
          end
          M_DQ, M_SQ: begin
            pf_v = 1'b1; pf_kind = K_ERROR; pf_err = E_OPEN_LITERAL; halted_next = 1'b1;
          end
          M_ANGLE: begin
            pf_v = 1'b1; pf_kind = K_ERROR; pf_err = E_NO_RANGLE; halted_next = 1'b1;
          end
          M_IDLE: end_v = 1'b1;
        endcase
      end else begin
        adv = 1'b1;
        unique case (mode)
          M_IDENT: begin
            if (ident_ch) begin
              tok_len_next = len_inc;
            end else begin
              pf_v      = 1'b1;
              take_idle = 1'b1;
            end
          end
          M_PAREN: begin
            if (text_byte == CH_STAR) begin
              tok_len_next = len_inc;
              mode_next    = M_COMMENT;
            end else begin
              pf_v      = 1'b1;
              pf_kind   = K_OPEN_GROUP;
              take_idle = 1'b1;
            end
          end
          M_COMMENT: begin
            tok_len_next = len_inc;
            if (text_byte == CH_STAR) mode_next = M_COMMENT_STAR;
          end
          M_COMMENT_STAR: begin
            tok_len_next = len_inc;
            if (text_byte == CH_RPAREN) begin
              mode_next = M_IDLE;
            end else if (text_byte != CH_STAR) begin
              mode_next = M_COMMENT;
            end
          end
          M_DQ, M_SQ: begin
            tok_len_next = len_inc;
            if ((mode == M_DQ && text_byte == CH_DQUOTE) ||
                (mode == M_SQ && text_byte == CH_SQUOTE)) begin
              pf_v      = 1'b1;
              pf_kind   = (mode == M_DQ) ? K_DQ : K_SQ;
              pf_len    = len_inc;
              mode_next = M_IDLE;
            end
          end
          M_ANGLE: begin
            if (ident_ch) begin
              tok_len_next = len_inc;
            end else if (text_byte == CH_GT) begin
              tok_len_next = len_inc;
              pf_v         = 1'b1;
              pf_len       = len_inc;
              mode_next    = M_IDLE;
            end else begin
              pf_v        = 1'b1;
              pf_kind     = K_ERROR;
              pf_err      = E_NO_RANGLE;
              halted_next = 1'b1;
              adv         = 1'b0;
            end
          end
          M_IDLE: take_idle = 1'b1;
        endcase

        if (take_idle) begin
          tok_line_next = cur_line;
          tok_col_next  = cur_col;
          tok_off_next  = byte_off;
          tok_len_next  = P'(1);
          mode_next     = cls.mode;
          id_v          = cls.emit;
          id_kind       = cls.kind;
        end

        if (adv) begin
          byte_off_next = sat_inc(byte_off);
          if (text_byte == CH_LF) begin
            cur_line_next = sat_inc(cur_line);
            cur_col_next  = P'(1);
          end else begin
            cur_col_next = sat_inc(cur_col);
          end
        end
      end
    end
  end

  // Result records: {last, err, kind, line, column, offset, length}
  always_comb begin
    rec_pf   = {pf_err, pf_kind, tok_line, tok_col, tok_off, pf_len};
    second_v = end_v | id_v;
    if (end_v) begin
      rec_second = {E_NONE, K_END, cur_line, cur_col, byte_off, {P{1'b0}}};
    end else begin
      rec_second = {E_NONE, id_kind, cur_line, cur_col, byte_off, P'(1)};
    end
    ctl.push0 = pf_v | second_v;
    ctl.push1 = pf_v & second_v;
    res0      = pf_v ? {~second_v, rec_pf} : {1'b1, rec_second};
    res1      = {1'b1, rec_second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      cur_line <= P'(1);
      cur_col  <= P'(1);
      byte_off <= '0;
      tok_line <= P'(1);
      tok_col  <= P'(1);
      tok_off  <= '0;
      tok_len  <= '0;
      halted   <= 1'b0;
    end else begin
      mode     <= mode_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      byte_off <= byte_off_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_off  <= tok_off_next;
      tok_len  <= tok_len_next;
      halted   <= halted_next;
    end
  end

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt cleared without reset");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !ctl.push0) else $error("result produced while halted");
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cur_line != '0) && (cur_col != '0)) else $error("line or column hit zero");
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (ctl.push0 && res0[REC_BITS-5 -: 5] == K_ERROR) |=> halted)
    else $error("error result without halt");
`endif
endmodule

// ===== hw/rtl/ebnf_tok_rbuf.sv =====
// ----------------------------------------------------------------------------
// ebnf_tok_rbuf
// Small result queue: takes up to two records per cycle, delivers one while out_stall is low.
// ----------------------------------------------------------------------------
module ebnf_tok_rbuf #(
  parameter int unsigned REC_BITS = 4 * ebnf_pkg::POSITION_BITS_DEF + 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ebnf_pkg::res_ctl_t    ctl,
  input  logic [REC_BITS-1:0]   res0,
  input  logic [REC_BITS-1:0]   res1,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [REC_BITS-1:0]   out_rec
);
  import ebnf_pkg::*;

  localparam int unsigned AW = $clog2(RBUF_DEPTH);
  localparam int unsigned CW = $clog2(RBUF_DEPTH + 1);

  logic [REC_BITS-1:0] mem [RBUF_DEPTH];
  logic [AW-1:0]       wr_ptr, rd_ptr;
  logic [CW-1:0]       count, count_next;
  logic                pop;

  assign out_valid = (count != '0);
  assign out_rec   = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= CW'(RBUF_DEPTH - 2));

  always_comb begin
    count_next = count + CW'(ctl.push0) + CW'(ctl.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (ctl.push0) mem[wr_ptr] <= res0;
    if (ctl.push1) mem[AW'(wr_ptr + 1'b1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= AW'(wr_ptr + AW'(ctl.push0) + AW'(ctl.push1));
      if (pop) rd_ptr <= AW'(rd_ptr + 1'b1);
      count <= count_next;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RBUF_DEPTH)) else $error("result queue overflow");
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    ctl.push1 |-> ctl.push0) else $error("second slot pushed alone");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push0 |-> $past(1'b1) && (count <= CW'(RBUF_DEPTH - 2) || ctl.push0 == 1'b0))
    else $error("push without room");
`endif
endmodule
